>>> design/tchc_pkg.sv
package tchc_pkg;

    // Phase of the capture sequence.
    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_WRITE = 2'd1,
        PH_HOLD  = 2'd2
    } t_phase;

    // Mode codes shared by the write and cooldown selections.
    localparam logic [1:0] MODE_TRIG  = 2'd0;
    localparam logic [1:0] MODE_STEPS = 2'd1;
    localparam logic [1:0] MODE_SPAN  = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_STEPS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SPAN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STEPS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_SPAN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_PREVIOUS = 3'd6;

    typedef struct packed {
        logic [1:0]  write_mode;
        logic [1:0]  hold_mode;
        logic [15:0] write_steps;
        logic [31:0] write_span;
        logic [15:0] hold_steps;
        logic [31:0] hold_span;
        logic        keep_previous;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [32:0] step_deadline;
        logic [32:0] time_deadline;
    } t_state;

    typedef struct packed {
        logic   write_now;
        logic   write_prior;
        logic   store_current;
        t_phase phase_after;
    } t_result;

    // The undefined mode code behaves as mode zero.
    function automatic logic [1:0] norm_mode(input logic [1:0] m);
        logic [1:0] r;
        r = (m == MODE_TRIG || m == MODE_STEPS || m == MODE_SPAN) ? m : MODE_TRIG;
        return r;
    endfunction

endpackage

>>> design/tchc_step.sv
module tchc_step (
    input  tchc_pkg::t_cfg    i_cfg,
    input  tchc_pkg::t_state  i_state,
    input  logic              i_trigger,
    input  logic [31:0]       i_step_index,
    input  logic [31:0]       i_now_time,
    output tchc_pkg::t_state  o_state,
    output tchc_pkg::t_result o_result
);
    import tchc_pkg::*;

    logic [1:0]  wm;
    logic [1:0]  hm;
    logic [32:0] idx33;
    logic [32:0] now33;
    logic [32:0] sum_write_steps;
    logic [32:0] sum_hold_steps;
    logic [32:0] sum_write_span;
    logic [32:0] sum_hold_span;
    logic        cont;
    logic        hold_over;
    logic        hold_imm;
    logic        begin_hold;
    logic        start_try;
    logic        start;
    logic        wr;
    t_phase      phase_n;

    assign wm    = norm_mode(i_cfg.write_mode);
    assign hm    = norm_mode(i_cfg.hold_mode);
    assign idx33 = {1'b0, i_step_index};
    assign now33 = {1'b0, i_now_time};

    // Candidate deadlines; the sums are exact in 33 bits.
    assign sum_write_steps = idx33 + {17'b0, i_cfg.write_steps};
    assign sum_hold_steps  = idx33 + {17'b0, i_cfg.hold_steps};
    assign sum_write_span  = now33 + {1'b0, i_cfg.write_span};
    assign sum_hold_span   = now33 + {1'b0, i_cfg.hold_span};

    // Cooldown end tests: against the stored deadlines, and for a cooldown that
    // starts in this step, which ends at once in trigger mode or for a zero step count.
    always_comb begin
        case (hm)
            MODE_STEPS: begin
                hold_over = idx33 >= i_state.step_deadline;
                hold_imm  = (i_cfg.hold_steps == 16'd0);
            end
            MODE_SPAN: begin
                hold_over = now33 > i_state.time_deadline;
                hold_imm  = 1'b0;
            end
            default: begin
                hold_over = 1'b1;
                hold_imm  = 1'b1;
            end
        endcase
    end

    // Phase decisions for this step.
    always_comb begin
        cont       = 1'b0;
        begin_hold = 1'b0;
        start_try  = 1'b0;
        case (i_state.phase)
            PH_WRITE: begin
                case (wm)
                    MODE_STEPS: cont = idx33 < i_state.step_deadline;
                    MODE_SPAN:  cont = now33 <= i_state.time_deadline;
                    default:    cont = i_trigger;
                endcase
                begin_hold = !cont;
                start_try  = !cont && hold_imm;
            end
            PH_HOLD: begin
                start_try = hold_over;
            end
            default: begin
                start_try = 1'b1;
            end
        endcase
    end

    assign start = start_try && i_trigger;
    assign wr    = cont || start;

    always_comb begin
        if (wr) begin
            phase_n = PH_WRITE;
        end else if (begin_hold && !hold_imm) begin
            phase_n = PH_HOLD;
        end else if (i_state.phase == PH_HOLD && !hold_over) begin
            phase_n = PH_HOLD;
        end else begin
            phase_n = PH_WAIT;
        end
    end

    // Deadline updates: a write start overrides a cooldown start in the same step.
    always_comb begin
        o_state.phase         = phase_n;
        o_state.step_deadline = i_state.step_deadline;
        o_state.time_deadline = i_state.time_deadline;
        if (begin_hold && hm == MODE_STEPS) begin
            o_state.step_deadline = sum_hold_steps;
        end
        if (begin_hold && hm == MODE_SPAN) begin
            o_state.time_deadline = sum_hold_span;
        end
        if (start && wm == MODE_STEPS) begin
            o_state.step_deadline = sum_write_steps;
        end
        if (start && wm == MODE_SPAN) begin
            o_state.time_deadline = sum_write_span;
        end
    end

    assign o_result.write_now     = wr;
    assign o_result.write_prior   = wr && i_cfg.keep_previous;
    assign o_result.store_current = !wr && i_cfg.keep_previous;
    assign o_result.phase_after   = phase_n;

endmodule

>>> design/triggered_capture_holdoff_controller_top.sv
// Triggered capture controller with hold-off. Each transfer on the input channel is one time
// step (trigger, step index, 16.16 time) and gives exactly one result transfer with the write,
// write-previous and store-current strobes and the phase after the step. One step is taken
// every cycle while results are taken: the step is held in an input register, evaluated
// by one pass of compares and 33-bit adds into the result register, and the phase and
// deadlines are updated in that same cycle. While a result waits to be taken the input
// register can still take one more step; after that the input stalls until the result
// transfer. Configuration writes are always accepted, and are to be made only while no
// step is in flight.
module triggered_capture_holdoff_controller_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tchc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_trigger,
    input  logic [31:0]                        i_step_index,
    input  logic [31:0]                        i_now_time,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_write_now,
    output logic                               o_write_prior,
    output logic                               o_store_current,
    output logic [1:0]                         o_phase_after
);
    import tchc_pkg::*;

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    t_result     r_result;
    t_result     n_result;
    logic        r_in_valid;
    logic        r_trigger;
    logic [31:0] r_step_index;
    logic [31:0] r_now_time;
    logic        r_out_valid;
    logic        advance;

    // The held step moves on when the result register is free or being emptied.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_mode    <= MODE_TRIG;
            r_cfg.hold_mode     <= MODE_TRIG;
            r_cfg.write_steps   <= 16'd1;
            r_cfg.write_span    <= 32'd0;
            r_cfg.hold_steps    <= 16'd0;
            r_cfg.hold_span     <= 32'd0;
            r_cfg.keep_previous <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WRITE_MODE:    r_cfg.write_mode    <= i_cfg_data[1:0];
                CFG_HOLD_MODE:     r_cfg.hold_mode     <= i_cfg_data[1:0];
                CFG_WRITE_STEPS:   r_cfg.write_steps   <= i_cfg_data[15:0];
                CFG_WRITE_SPAN:    r_cfg.write_span    <= i_cfg_data;
                CFG_HOLD_STEPS:    r_cfg.hold_steps    <= i_cfg_data[15:0];
                CFG_HOLD_SPAN:     r_cfg.hold_span     <= i_cfg_data;
                CFG_KEEP_PREVIOUS: r_cfg.keep_previous <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_trigger    <= i_trigger;
            r_step_index <= i_step_index;
            r_now_time   <= i_now_time;
        end
    end

    // One step of the phase machine.
    tchc_step u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_trigger    (r_trigger),
        .i_step_index (r_step_index),
        .i_now_time   (r_now_time),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // Phase and deadlines advance with each evaluated step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_WAIT;
            r_state.step_deadline <= 33'd0;
            r_state.time_deadline <= 33'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_now     = r_result.write_now;
    assign o_write_prior   = r_result.write_prior;
    assign o_store_current = r_result.store_current;
    assign o_phase_after   = r_result.phase_after;

`ifndef ASSERT_OFF
    // A step is written exactly when it leaves the block in the writing phase.
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_write_now == (o_phase_after == PH_WRITE)))
        else $error("write strobe disagrees with phase after step");

    // The previous-step strobes never fire together.
    a_prior_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_write_prior && o_store_current))
        else $error("write-previous and store-current both set");

    // A held step is not dropped while the result side stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("held step lost during stall");
`endif

endmodule

>>> tb/capture_strobe_checker.sv
module capture_strobe_checker
    import tchc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_trigger,
    input  logic [31:0]          i_step_index,
    input  logic [31:0]          i_now_time,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_write_now,
    input  logic                 i_write_prior,
    input  logic                 i_store_current,
    input  logic [1:0]           i_phase_after,
    output int unsigned          o_mismatches,
    output int unsigned          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the registers and of the capture state.
    t_cfg    shadow;
    t_state  track;
    t_result pending_strobes[$];

    // The spare mode code behaves as mode zero.
    function automatic logic [1:0] effective_mode(input logic [1:0] m);
        return (m > MODE_SPAN) ? MODE_TRIG : m;
    endfunction

    // True once the cooldown has run its course for this step.
    function automatic logic cooldown_done(input logic [31:0] idx, input logic [31:0] now);
        case (effective_mode(shadow.hold_mode))
            MODE_STEPS: return {1'b0, idx} >= track.step_deadline;
            MODE_SPAN:  return {1'b0, now} > track.time_deadline;
            default:    return 1'b1;
        endcase
    endfunction

    // Waiting-phase test: a trigger starts writing and sets the write deadline.
    task automatic arm_capture(input logic trig, input logic [31:0] idx,
                               input logic [31:0] now, output logic wr);
        wr = trig;
        if (trig) begin
            track.phase = PH_WRITE;
            case (effective_mode(shadow.write_mode))
                MODE_STEPS: track.step_deadline = {1'b0, idx} + {17'd0, shadow.write_steps};
                MODE_SPAN:  track.time_deadline = {1'b0, now} + {1'b0, shadow.write_span};
                default: ;
            endcase
        end
    endtask

    // One time step of the capture sequence, giving the strobes it should raise.
    task automatic advance_capture(input logic trig, input logic [31:0] idx,
                                   input logic [31:0] now, output t_result res);
        logic wr;
        logic start_hold;
        wr = 1'b0;
        start_hold = 1'b0;
        case (track.phase)
            PH_WRITE: begin
                case (effective_mode(shadow.write_mode))
                    MODE_STEPS: wr = {1'b0, idx} < track.step_deadline;
                    MODE_SPAN:  wr = {1'b0, now} <= track.time_deadline;
                    default:    wr = trig;
                endcase
                start_hold = !wr;
            end
            PH_HOLD: begin
                if (cooldown_done(idx, now)) begin
                    track.phase = PH_WAIT;
                    arm_capture(trig, idx, now, wr);
                end
            end
            default: begin
                track.phase = PH_WAIT;
                arm_capture(trig, idx, now, wr);
            end
        endcase

        // Writing has ended: enter the cooldown, which may be over in this same step.
        if (start_hold) begin
            track.phase = PH_HOLD;
            case (effective_mode(shadow.hold_mode))
                MODE_STEPS: track.step_deadline = {1'b0, idx} + {17'd0, shadow.hold_steps};
                MODE_SPAN:  track.time_deadline = {1'b0, now} + {1'b0, shadow.hold_span};
                default: ;
            endcase
            if (cooldown_done(idx, now)) begin
                track.phase = PH_WAIT;
                arm_capture(trig, idx, now, wr);
            end
        end

        res.write_now     = wr;
        res.write_prior   = wr && shadow.keep_previous;
        res.store_current = !wr && shadow.keep_previous;
        res.phase_after   = track.phase;
    endtask

    // Register writes keep only the bits each register holds.
    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        case (idx)
            CFG_WRITE_MODE:    shadow.write_mode    = data[1:0];
            CFG_HOLD_MODE:     shadow.hold_mode     = data[1:0];
            CFG_WRITE_STEPS:   shadow.write_steps   = data[15:0];
            CFG_WRITE_SPAN:    shadow.write_span    = data;
            CFG_HOLD_STEPS:    shadow.hold_steps    = data[15:0];
            CFG_HOLD_SPAN:     shadow.hold_span     = data;
            CFG_KEEP_PREVIOUS: shadow.keep_previous = data[0];
            default: ;
        endcase
    endtask

    task automatic compare_field(input string field, input logic [1:0] want,
                                 input logic [1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            o_mismatches++;
        end
    endtask

    // Watch every transfer: results are checked before the step of the same edge is queued.
    always @(posedge i_clk) begin : watch
        t_result want;
        t_result fresh;
        if (!i_rst_n) begin
            shadow = '{write_mode: MODE_TRIG, hold_mode: MODE_TRIG, write_steps: 16'd1,
                       write_span: '0, hold_steps: '0, hold_span: '0, keep_previous: 1'b0};
            track = '{phase: PH_WAIT, step_deadline: '0, time_deadline: '0};
            pending_strobes.delete();
            o_mismatches = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_strobes.size() == 0) begin
                    $display("%0t ns: result transfer with no step outstanding", $time);
                    o_mismatches++;
                end else begin
                    want = pending_strobes.pop_front();
                    compare_field("write_now", want.write_now, i_write_now);
                    compare_field("write_prior", want.write_prior, i_write_prior);
                    compare_field("store_current", want.store_current, i_store_current);
                    compare_field("phase_after", want.phase_after, i_phase_after);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) begin
                advance_capture(i_trigger, i_step_index, i_now_time, fresh);
                pending_strobes.push_back(fresh);
            end
        end
        o_pending <= pending_strobes.size();
    end

endmodule

>>> tb/triggered_capture_holdoff_controller_top_tb.sv
module triggered_capture_holdoff_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tchc_pkg::*;

    // Mode code with no defined meaning, and a register index past the list.
    localparam logic [1:0]           MODE_UNDEF     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam int unsigned          RUN_LIMIT      = 200000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_trigger;
    logic [31:0]          i_step_index;
    logic [31:0]          i_now_time;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_write_now;
    logic                 o_write_prior;
    logic                 o_store_current;
    logic [1:0]           o_phase_after;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned cycle_count = 0;
    int unsigned send_gap_pct = 13;
    int unsigned stall_pct = 55;

    triggered_capture_holdoff_controller_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_trigger       (i_trigger),
        .i_step_index    (i_step_index),
        .i_now_time      (i_now_time),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_write_now     (o_write_now),
        .o_write_prior   (o_write_prior),
        .o_store_current (o_store_current),
        .o_phase_after   (o_phase_after)
    );

    capture_strobe_checker strobe_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_trigger       (i_trigger),
        .i_step_index    (i_step_index),
        .i_now_time      (i_now_time),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_write_now     (o_write_now),
        .i_write_prior   (o_write_prior),
        .i_store_current (o_store_current),
        .i_phase_after   (o_phase_after),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    always begin
        #2ns i_clk = 1'b1;
        #2ns i_clk = 1'b0;
    end

    // The result side stalls at random.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // One register transfer; valid is left high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write every register, with junk in the unused upper bits, then a stray index.
    task automatic set_config(input logic [1:0] wm, input logic [1:0] hm,
                              input logic [15:0] ws, input logic [31:0] wspan,
                              input logic [15:0] hs, input logic [31:0] hspan,
                              input logic kp);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_WRITE_MODE, {junk[31:2], wm});
        write_reg(CFG_HOLD_MODE, {junk[29:0], hm});
        write_reg(CFG_WRITE_STEPS, {junk[31:16], ws});
        write_reg(CFG_WRITE_SPAN, wspan);
        write_reg(CFG_HOLD_STEPS, {junk[15:0], hs});
        write_reg(CFG_HOLD_SPAN, hspan);
        write_reg(CFG_KEEP_PREVIOUS, {junk[31:1], kp});
        write_reg(CFG_IDX_UNUSED, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // One step transfer, after a random gap; valid is left high for a following step.
    task automatic send_step(input logic trig, input logic [31:0] idx, input logic [31:0] now);
        if ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        i_in_valid   <= 1'b1;
        i_trigger    <= trig;
        i_step_index <= idx;
        i_now_time   <= now;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop sending and wait until every result has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly small counts and spans so that phases turn over often, with the extremes mixed in.
    task automatic random_config();
        logic [15:0] ws;
        logic [15:0] hs;
        logic [31:0] wspan;
        logic [31:0] hspan;
        case ($urandom_range(7))
            0:       ws = '0;
            1:       ws = '1;
            default: ws = 16'($urandom_range(1, 8));
        endcase
        case ($urandom_range(7))
            0:       hs = '1;
            default: hs = 16'($urandom_range(0, 6));
        endcase
        case ($urandom_range(7))
            0:       wspan = '0;
            1:       wspan = '1;
            default: wspan = $urandom_range(0, 32'h8_0000);
        endcase
        case ($urandom_range(7))
            0:       hspan = '0;
            1:       hspan = '1;
            default: hspan = $urandom_range(0, 32'h8_0000);
        endcase
        set_config(2'($urandom_range(3)), 2'($urandom_range(3)), ws, wspan, hs, hspan,
                   1'($urandom_range(1)));
    endtask

    // A run of consecutive time steps with trigger bursts, and the odd jump in index or time.
    task automatic run_sequence(input int n);
        logic [31:0] idx;
        logic [31:0] now;
        logic        trig;
        idx  = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(20) : $urandom;
        now  = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(32'h4_0000)
                                        : $urandom;
        trig = 1'($urandom_range(1));
        repeat (n) begin
            if ($urandom_range(3) == 0)
                trig = !trig;
            send_step(trig, idx, now);
            idx = ($urandom_range(19) == 0) ? $urandom : idx + 1;
            now = ($urandom_range(19) == 0) ? $urandom : now + $urandom_range(0, 32'h3_0000);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_trigger    = 1'b0;
        i_step_index = '0;
        i_now_time   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register values after reset, with the extremes of index and time.
        send_step(1'b1, 32'h0, 32'h0);
        send_step(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_step(1'b0, 32'hFFFF_FFFF, 32'h0);
        send_step(1'b1, 32'h0, 32'hFFFF_FFFF);
        drain();

        // Zero write steps cover only the trigger step; a zero step cooldown ends at once.
        set_config(MODE_STEPS, MODE_STEPS, 16'd0, 32'd0, 16'd0, 32'd0, 1'b1);
        send_step(1'b1, 32'd10, 32'd0);
        send_step(1'b0, 32'd11, 32'd0);
        send_step(1'b1, 32'd12, 32'd0);
        send_step(1'b1, 32'd13, 32'd0);
        drain();

        // Zero write span and a zero interval cooldown, which lasts at least one more step.
        set_config(MODE_SPAN, MODE_SPAN, 16'd1, 32'd0, 16'd0, 32'd0, 1'b1);
        send_step(1'b1, 32'd0, 32'h5_0000);
        send_step(1'b1, 32'd1, 32'h5_0000);
        send_step(1'b0, 32'd2, 32'h5_0000);
        send_step(1'b0, 32'd3, 32'h5_0001);
        send_step(1'b1, 32'd4, 32'hFFFF_FFFF);
        drain();

        // The spare mode codes act as trigger-held writing and no cooldown.
        set_config(MODE_UNDEF, MODE_UNDEF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                   32'hFFFF_FFFF, 1'b0);
        send_step(1'b1, 32'd5, 32'd0);
        send_step(1'b1, 32'd6, 32'd1);
        send_step(1'b0, 32'd7, 32'd2);
        send_step(1'b1, 32'd8, 32'd3);
        drain();

        // A step deadline past 32 bits keeps writing across the index wrap.
        set_config(MODE_STEPS, MODE_TRIG, 16'hFFFF, 32'd0, 16'd0, 32'd0, 1'b1);
        send_step(1'b1, 32'hFFFF_FFF0, 32'd0);
        send_step(1'b0, 32'hFFFF_FFFF, 32'd0);
        send_step(1'b0, 32'h0, 32'd0);
        drain();

        // With no cooldown, a held trigger starts writing again in the step that ends it.
        set_config(MODE_STEPS, MODE_TRIG, 16'd1, 32'd0, 16'd0, 32'd0, 1'b0);
        send_step(1'b1, 32'd20, 32'd0);
        send_step(1'b1, 32'd21, 32'd0);
        drain();

        // Random settings under each pattern of sender and receiver idling.
        for (int prof = 0; prof < 3; prof++) begin
            case (prof)
                0: begin
                    send_gap_pct = 13;
                    stall_pct    = 55;
                end
                1: begin
                    send_gap_pct = 55;
                    stall_pct    = 13;
                end
                default: begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
            endcase
            for (int ph = 0; ph < 6; ph++) begin
                random_config();
                run_sequence(40);
                drain();
            end
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
